// ===== rtl/triggered_burst_energy_meter_core_macros.svh =====
// Assertion macros shared by the burst energy meter modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef TRIGGERED_BURST_ENERGY_METER_CORE_MACROS_SVH
`define TRIGGERED_BURST_ENERGY_METER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("burst energy meter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("burst energy meter assertion failed");

`endif

// ===== rtl/tbem_pkg.sv =====
// Shared types, constants and the divide-by-125 digit function of the burst energy meter.
// No dependencies; the top level, tbem_front and tbem_back import this package.
package tbem_pkg;

    localparam int NUM_W       = 8;
    localparam int PERIOD_W    = 16;
    localparam int LIMIT_W     = 8;
    localparam int POWER_W     = 28;
    localparam int TIME_W      = 32;
    localparam int ENERGY_W    = 51;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [POWER_W-1:0] POWER_MAX  = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX   = '1;
    localparam logic [PERIOD_W-1:0] SINCE_MAX = '1;

    localparam logic [PERIOD_W-1:0] PEAK_PERIOD_RST  = 16'd1600;
    localparam logic [PERIOD_W-1:0] TAIL_PERIOD_RST  = 16'd1000;
    localparam logic [LIMIT_W-1:0]  STALL_LIMIT_RST  = 8'd10;
    localparam logic [LIMIT_W-1:0]  BURST_LENGTH_RST = 8'd50;

    // Energy = floor(sum * time / 1000) = floor(floor(sum * time / 8) / 125).
    localparam int PROD_FULL_W   = POWER_W + TIME_W;
    localparam int DIV_PRE_SHIFT = 3;
    localparam int DIGIT_W       = 8;
    localparam int WORK_W        = 64;
    localparam int NDIG          = WORK_W / DIGIT_W;
    localparam int REM_W         = 7;
    localparam int DIGIT_X_W     = REM_W + DIGIT_W;
    localparam int RECIP_W       = 23;
    localparam int RECIP_SHIFT   = 14;
    localparam logic [RECIP_W-1:0]   DIV_RECIP = 23'd131;
    localparam logic [DIGIT_X_W:0]   DIV_BASE  = 16'd125;

    typedef enum logic {
        ST_IDLE,
        ST_CAPTURE
    } state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PEAK_PERIOD  = 4'd0,
        CFG_TAIL_PERIOD  = 4'd1,
        CFG_STALL_LIMIT  = 4'd2,
        CFG_BURST_LENGTH = 4'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] peak_period;
        logic [PERIOD_W-1:0] tail_period;
        logic [LIMIT_W-1:0]  stall_limit;
        logic [LIMIT_W-1:0]  burst_length;
    } cfg_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] q;
        logic [REM_W-1:0]   r;
    } digit_t;

    // One radix-256 step of long division by 125. The input is the running
    // remainder (below 125) followed by the next dividend byte. The scaled
    // reciprocal never overestimates and is short by at most one.
    function automatic digit_t div125_digit(input logic [DIGIT_X_W-1:0] x);
        logic [RECIP_W-1:0]  prod;
        logic [DIGIT_W-1:0]  q;
        logic [DIGIT_X_W:0]  rem;
        digit_t              res;
        prod = RECIP_W'(x) * DIV_RECIP;
        q    = DIGIT_W'(prod >> RECIP_SHIFT);
        rem  = (DIGIT_X_W + 1)'(x) - (DIGIT_X_W + 1)'(q) * DIV_BASE;
        if (rem >= DIV_BASE) begin
            q   = q + 1'b1;
            rem = rem - DIV_BASE;
        end
        res.q = q;
        res.r = REM_W'(rem);
        return res;
    endfunction

endpackage

// ===== rtl/triggered_burst_energy_meter_core.sv =====
// Top level of the triggered burst energy meter: configuration registers and module wiring.
// Depends on tbem_pkg, tbem_front, tbem_queue and tbem_back.

// Each input transaction is one microsecond tick and the core takes one tick per clock.
// While idle, a tick with the trigger flag set starts a burst; the core then samples
// whenever the ticks since the last sample reach the current period (peak period first,
// tail period once the acceleration peak has stalled for stall_limit samples), and every
// sample yields one output transaction. The final sample of a burst, flagged by tlast,
// also carries the power sums, the elapsed ticks and both energies, computed as
// floor(sum * ticks / 1000). A sample reaches the output through the queue, the energy
// multiply register and the divide, which works through the product one byte per
// pipeline stage. With m_tready held high the sustained rate is one tick per cycle;
// a four-entry queue between the tick front end and the energy pipeline absorbs output
// back-pressure, and s_tready drops only when it is full.
// Configuration writes set the periods, stall limit and burst length and should only be
// issued while no burst is running and no result is pending; cfg_ready is always high.
module triggered_burst_energy_meter_core
    import tbem_pkg::*;
#(
    parameter int ADC_BITS   = 10,
    parameter int ACCEL_BITS = 13,
    localparam int IN_W  = ((ACCEL_BITS + 4 * ADC_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((NUM_W + ACCEL_BITS + 4 * ADC_BITS + 2 * POWER_W + TIME_W
                             + 2 * ENERGY_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Tick input. tdata from bit 0: accel_z, adc_volt_two, adc_volt_one,
    // adc_curr_two, adc_curr_one, zero fill. tuser: trigger.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,
    input  logic                   s_tuser,
    // Sample output. tdata from bit 0: sample_number, sampled_z, out_volt_two,
    // out_volt_one, out_curr_two, out_curr_one, power_sum_one, power_sum_two,
    // burst_time_us, energy_one, energy_two, zero fill. tlast: last.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tlast
);

    localparam int REC_W = NUM_W + ACCEL_BITS + 4 * ADC_BITS + 1 + 2 * POWER_W + TIME_W;

    cfg_t             cfg_reg;
    logic             push;
    logic [REC_W-1:0] push_data;
    logic             queue_full;
    logic             pop;
    logic [REC_W-1:0] pop_data;
    logic             queue_empty;

    assign cfg_ready = 1'b1;

    // Writes to indexes beyond the register list are accepted and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_period  <= PEAK_PERIOD_RST;
            cfg_reg.tail_period  <= TAIL_PERIOD_RST;
            cfg_reg.stall_limit  <= STALL_LIMIT_RST;
            cfg_reg.burst_length <= BURST_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PEAK_PERIOD:  cfg_reg.peak_period  <= cfg_data[PERIOD_W-1:0];
                CFG_TAIL_PERIOD:  cfg_reg.tail_period  <= cfg_data[PERIOD_W-1:0];
                CFG_STALL_LIMIT:  cfg_reg.stall_limit  <= cfg_data[LIMIT_W-1:0];
                CFG_BURST_LENGTH: cfg_reg.burst_length <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick handling: burst control, peak tracking and power sums.
    tbem_front #(
        .ADC_BITS   (ADC_BITS),
        .ACCEL_BITS (ACCEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Decouples tick acceptance from output back-pressure.
    tbem_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // Energy computation and the output register.
    tbem_back #(
        .ADC_BITS   (ADC_BITS),
        .ACCEL_BITS (ACCEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== rtl/tbem_front.sv =====
// Front end of the burst energy meter: per-tick burst control and power accumulation.
// Depends on tbem_pkg and the assertion macro header; pushes sample records to tbem_queue.
`include "triggered_burst_energy_meter_core_macros.svh"

module tbem_front
    import tbem_pkg::*;
#(
    parameter int ADC_BITS   = 10,
    parameter int ACCEL_BITS = 13,
    localparam int IN_W  = ((ACCEL_BITS + 4 * ADC_BITS + 7) / 8) * 8,
    localparam int REC_W = NUM_W + ACCEL_BITS + 4 * ADC_BITS + 1 + 2 * POWER_W + TIME_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,
    input  logic             queue_full,
    output logic             push,
    output logic [REC_W-1:0] push_data
);

    localparam int PROD_W = 2 * ADC_BITS;
    localparam int ADD_W  = ((PROD_W > POWER_W) ? PROD_W : POWER_W) + 1;

    typedef struct packed {
        logic [TIME_W-1:0]            burst_time;
        logic [POWER_W-1:0]           sum_two;
        logic [POWER_W-1:0]           sum_one;
        logic                         last;
        logic [ADC_BITS-1:0]          curr_one;
        logic [ADC_BITS-1:0]          curr_two;
        logic [ADC_BITS-1:0]          volt_one;
        logic [ADC_BITS-1:0]          volt_two;
        logic signed [ACCEL_BITS-1:0] z;
        logic [NUM_W-1:0]             num;
    } rec_t;

    state_t                       state_reg, state_next;
    logic [TIME_W-1:0]            timer_reg, timer_next;
    logic [PERIOD_W-1:0]          since_reg, since_next;
    logic                         tail_reg, tail_next;
    logic signed [ACCEL_BITS-1:0] peak_reg, peak_next;
    logic [LIMIT_W-1:0]           stall_reg, stall_next;
    logic [NUM_W-1:0]             cnt_reg, cnt_next;
    logic [POWER_W-1:0]           acc1_reg, acc1_next;
    logic [POWER_W-1:0]           acc2_reg, acc2_next;

    logic                         tick;
    logic                         start;
    logic                         active;
    logic                         take;
    logic                         fin;
    logic [TIME_W-1:0]            timer_e;
    logic [PERIOD_W-1:0]          since_e;
    logic                         tail_e;
    logic signed [ACCEL_BITS-1:0] peak_e;
    logic [NUM_W-1:0]             cnt_e;
    logic [NUM_W-1:0]             cnt_inc;
    logic [POWER_W-1:0]           acc1_e, acc2_e;
    logic [POWER_W-1:0]           acc1_new, acc2_new;
    logic [PERIOD_W-1:0]          period;
    logic signed [ACCEL_BITS-1:0] in_z, z_e;
    logic [ADC_BITS-1:0]          volt_two, volt_one, curr_two, curr_one;
    logic [PROD_W-1:0]            prod1, prod2;
    logic [ADD_W-1:0]             sum1, sum2;
    logic [LIMIT_W-1:0]           stall_inc;
    rec_t                         rec;

    assign in_z     = s_tdata[ACCEL_BITS-1:0];
    assign volt_two = s_tdata[ACCEL_BITS +: ADC_BITS];
    assign volt_one = s_tdata[ACCEL_BITS + ADC_BITS +: ADC_BITS];
    assign curr_two = s_tdata[ACCEL_BITS + 2 * ADC_BITS +: ADC_BITS];
    assign curr_one = s_tdata[ACCEL_BITS + 3 * ADC_BITS +: ADC_BITS];

    // Every tick may yield a sample, so a tick is taken only with queue room.
    assign s_tready = !queue_full;
    assign tick     = s_tvalid && s_tready;

    always_comb
    begin
        start  = (state_reg == ST_IDLE) && s_tuser;
        active = (state_reg == ST_CAPTURE) || start;

        // Values as seen after the trigger clear or the per-tick count-up.
        timer_e = start ? '0 : ((timer_reg == TIME_MAX) ? timer_reg : timer_reg + 1'b1);
        since_e = start ? '0 : ((since_reg == SINCE_MAX) ? since_reg : since_reg + 1'b1);
        tail_e  = start ? 1'b0 : tail_reg;
        peak_e  = start ? '0 : peak_reg;
        cnt_e   = start ? '0 : cnt_reg;
        acc1_e  = start ? '0 : acc1_reg;
        acc2_e  = start ? '0 : acc2_reg;

        period = tail_e ? cfg.tail_period : cfg.peak_period;
        take   = active && (since_e >= period);
        z_e    = tail_e ? '0 : in_z;

        prod1    = PROD_W'(volt_one) * PROD_W'(curr_one);
        prod2    = PROD_W'(volt_two) * PROD_W'(curr_two);
        sum1     = ADD_W'(acc1_e) + ADD_W'(prod1);
        sum2     = ADD_W'(acc2_e) + ADD_W'(prod2);
        acc1_new = (sum1 > ADD_W'(POWER_MAX)) ? POWER_MAX : sum1[POWER_W-1:0];
        acc2_new = (sum2 > ADD_W'(POWER_MAX)) ? POWER_MAX : sum2[POWER_W-1:0];

        cnt_inc   = cnt_e + 1'b1;
        fin       = (cnt_inc == cfg.burst_length);
        stall_inc = stall_reg + 1'b1;

        state_next = state_reg;
        timer_next = timer_e;
        since_next = since_e;
        tail_next  = tail_e;
        peak_next  = peak_e;
        stall_next = stall_reg;
        cnt_next   = cnt_e;
        acc1_next  = acc1_e;
        acc2_next  = acc2_e;

        if (start)
        begin
            state_next = ST_CAPTURE;
        end

        if (take)
        begin
            since_next = '0;
            if (z_e > peak_e)
            begin
                peak_next  = z_e;
                stall_next = '0;
            end
            else if (stall_inc >= cfg.stall_limit)
            begin
                stall_next = '0;
                tail_next  = 1'b1;
            end
            else
            begin
                stall_next = stall_inc;
            end

            if (fin)
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
                acc1_next  = '0;
                acc2_next  = '0;
            end
            else
            begin
                cnt_next  = cnt_inc;
                acc1_next = acc1_new;
                acc2_next = acc2_new;
            end
        end

        rec.num        = cnt_e;
        rec.z          = z_e;
        rec.volt_two   = volt_two;
        rec.volt_one   = volt_one;
        rec.curr_two   = curr_two;
        rec.curr_one   = curr_one;
        rec.last       = fin;
        rec.sum_one    = fin ? acc1_new : '0;
        rec.sum_two    = fin ? acc2_new : '0;
        rec.burst_time = fin ? timer_e : '0;
    end

    assign push      = tick && take;
    assign push_data = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            timer_reg <= '0;
            since_reg <= '0;
            tail_reg  <= 1'b0;
            peak_reg  <= '0;
            stall_reg <= '0;
            cnt_reg   <= '0;
            acc1_reg  <= '0;
            acc2_reg  <= '0;
        end
        else if (tick && active)
        begin
            state_reg <= state_next;
            timer_reg <= timer_next;
            since_reg <= since_next;
            tail_reg  <= tail_next;
            peak_reg  <= peak_next;
            stall_reg <= stall_next;
            cnt_reg   <= cnt_next;
            acc1_reg  <= acc1_next;
            acc2_reg  <= acc2_next;
        end
    end

    // A burst only ends on the tick that delivers its final sample.
    `TBEM_ASSERT_NEXT(a_front_capture_holds, (state_reg == ST_CAPTURE) && !(push && fin), state_reg == ST_CAPTURE)
    // While idle, the sample counter and both power sums are clear.
    `TBEM_ASSERT_NOW(a_front_idle_clear, state_reg == ST_IDLE, (cnt_reg == '0) && (acc1_reg == '0) && (acc2_reg == '0))

endmodule

// ===== rtl/tbem_queue.sv =====
// Short first-in first-out queue between the front end and the energy pipeline.
// Depends on the assertion macro header only.
`include "triggered_burst_energy_meter_core_macros.svh"

module tbem_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TBEM_ASSERT_NOW(a_queue_no_overflow, push, !full)
    `TBEM_ASSERT_NOW(a_queue_no_underflow, pop, !empty)

endmodule

// ===== rtl/tbem_back.sv =====
// Back end of the burst energy meter: energy multiply, divide by 1000 and result register.
// Depends on tbem_pkg and the assertion macro header; pops sample records from tbem_queue.
`include "triggered_burst_energy_meter_core_macros.svh"

module tbem_back
    import tbem_pkg::*;
#(
    parameter int ADC_BITS   = 10,
    parameter int ACCEL_BITS = 13,
    localparam int REC_W = NUM_W + ACCEL_BITS + 4 * ADC_BITS + 1 + 2 * POWER_W + TIME_W,
    localparam int OUT_W = ((NUM_W + ACCEL_BITS + 4 * ADC_BITS + 2 * POWER_W + TIME_W
                             + 2 * ENERGY_W + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  logic [REC_W-1:0] pop_data,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    typedef struct packed {
        logic [TIME_W-1:0]            burst_time;
        logic [POWER_W-1:0]           sum_two;
        logic [POWER_W-1:0]           sum_one;
        logic                         last;
        logic [ADC_BITS-1:0]          curr_one;
        logic [ADC_BITS-1:0]          curr_two;
        logic [ADC_BITS-1:0]          volt_one;
        logic [ADC_BITS-1:0]          volt_two;
        logic signed [ACCEL_BITS-1:0] z;
        logic [NUM_W-1:0]             num;
    } rec_t;

    logic                   en;
    rec_t                   pop_rec;
    logic                   mv_reg;
    rec_t                   mrec_reg;
    logic [PROD_FULL_W-1:0] mp1_reg, mp2_reg;

    logic                   dv_reg    [NDIG];
    rec_t                   drec_reg  [NDIG];
    logic [WORK_W-1:0]      dwork1_reg[NDIG];
    logic [WORK_W-1:0]      dwork2_reg[NDIG];
    logic [REM_W-1:0]       drem1_reg [NDIG];
    logic [REM_W-1:0]       drem2_reg [NDIG];

    logic [WORK_W-1:0]      dwork1_next[NDIG];
    logic [WORK_W-1:0]      dwork2_next[NDIG];
    logic [REM_W-1:0]       drem1_next [NDIG];
    logic [REM_W-1:0]       drem2_next [NDIG];

    rec_t                   orec;
    logic [ENERGY_W-1:0]    energy1, energy2;

    // The whole pipeline holds while a result waits at the output.
    assign en  = !(dv_reg[NDIG-1] && !m_tready);
    assign pop = en && !queue_empty;

    assign pop_rec = rec_t'(pop_data);

    // Each stage divides by 125 one byte at a time, most significant first;
    // the quotient bytes shift in from the right as the dividend leaves.
    always_comb
    begin
        logic [WORK_W-1:0] w1, w2;
        logic [REM_W-1:0]  r1, r2;
        digit_t            d1, d2;
        for (int i = 0; i < NDIG; i++)
        begin
            if (i == 0)
            begin
                w1 = WORK_W'(mp1_reg >> DIV_PRE_SHIFT);
                w2 = WORK_W'(mp2_reg >> DIV_PRE_SHIFT);
                r1 = '0;
                r2 = '0;
            end
            else
            begin
                w1 = dwork1_reg[i-1];
                w2 = dwork2_reg[i-1];
                r1 = drem1_reg[i-1];
                r2 = drem2_reg[i-1];
            end
            d1 = div125_digit({r1, w1[WORK_W-1 -: DIGIT_W]});
            d2 = div125_digit({r2, w2[WORK_W-1 -: DIGIT_W]});
            dwork1_next[i] = {w1[WORK_W-DIGIT_W-1:0], d1.q};
            dwork2_next[i] = {w2[WORK_W-DIGIT_W-1:0], d2.q};
            drem1_next[i]  = d1.r;
            drem2_next[i]  = d2.r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            for (int i = 0; i < NDIG; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            mv_reg    <= pop;
            dv_reg[0] <= mv_reg;
            for (int i = 1; i < NDIG; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mrec_reg <= pop_rec;
            // Sums and time are zero on samples that are not last.
            mp1_reg  <= PROD_FULL_W'(pop_rec.sum_one) * PROD_FULL_W'(pop_rec.burst_time);
            mp2_reg  <= PROD_FULL_W'(pop_rec.sum_two) * PROD_FULL_W'(pop_rec.burst_time);
            drec_reg[0] <= mrec_reg;
            for (int i = 1; i < NDIG; i++)
            begin
                drec_reg[i] <= drec_reg[i-1];
            end
            for (int i = 0; i < NDIG; i++)
            begin
                dwork1_reg[i] <= dwork1_next[i];
                dwork2_reg[i] <= dwork2_next[i];
                drem1_reg[i]  <= drem1_next[i];
                drem2_reg[i]  <= drem2_next[i];
            end
        end
    end

    assign orec    = drec_reg[NDIG-1];
    assign energy1 = dwork1_reg[NDIG-1][ENERGY_W-1:0];
    assign energy2 = dwork2_reg[NDIG-1][ENERGY_W-1:0];

    assign m_tvalid = dv_reg[NDIG-1];
    assign m_tlast  = orec.last;
    assign m_tdata  = OUT_W'({energy2, energy1, orec.burst_time, orec.sum_two, orec.sum_one,
                              orec.curr_one, orec.curr_two, orec.volt_one, orec.volt_two,
                              orec.z, orec.num});

    // Energies only come out of the final sample of a burst.
    `TBEM_ASSERT_NOW(a_back_zero_energy, m_tvalid && !m_tlast, (energy1 == '0) && (energy2 == '0))
    // A stalled result keeps its place until it is taken.
    `TBEM_ASSERT_NEXT(a_back_hold_result, m_tvalid && !m_tready, m_tvalid && (m_tlast == $past(m_tlast)))

endmodule
